// ----- src/binary_min_heap_edge_queue_macros.svh -----
// Assertion macros shared by the checker of the edge queue.
// Depends on nothing; the user supplies clk and arst_n in scope.
`ifndef BINARY_MIN_HEAP_EDGE_QUEUE_MACROS_SVH
`define BINARY_MIN_HEAP_EDGE_QUEUE_MACROS_SVH

// Same-cycle implication, checked on the rising edge of clk outside reset.
`define BMHEQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, checked on the rising edge of clk outside reset.
`define BMHEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ----- src/bmheq_pkg.sv -----
// Shared types and constants of the binary min-heap edge queue.
// Depends on nothing; used by the controller and the top level.
package bmheq_pkg;

	localparam int CAPACITY    = 1024;
	localparam int IDX_W       = 10;
	localparam int CNT_W       = 11;
	localparam int VERT_W      = 8;
	localparam int WEIGHT_BITS = 16;

	typedef enum logic [2:0] {
		MODE_INSERT   = 3'd0,
		MODE_EXTRACT  = 3'd1,
		MODE_PEEK     = 3'd2,
		MODE_DECREASE = 3'd3,
		MODE_DELETE   = 3'd4
	} mode_e;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2,
		STATUS_INDEX = 2'd3
	} status_e;

	typedef struct packed {
		logic [WEIGHT_BITS-1:0] weight;
		logic [VERT_W-1:0]      to_v;
		logic [VERT_W-1:0]      from_v;
	} entry_t;

	typedef struct packed {
		logic                  we;
		logic [IDX_W-1:0]      waddr;
		entry_t                wdata;
		logic [IDX_W-1:0]      raddr;
	} ram_req_t;

	typedef struct packed {
		status_e               status;
		logic [VERT_W:0]       out_from;
		logic [VERT_W:0]       out_to;
		logic [WEIGHT_BITS:0]  out_weight;
		logic [CNT_W-1:0]      entry_count;
	} result_t;

endpackage

// ----- src/binary_min_heap_edge_queue.sv -----
// Binary min-heap of graph edges with a stream interface on either side.
// Depends on bmheq_pkg, bmheq_ctrl and bmheq_ram.
//
// The heap lives in a 1024-entry RAM and is walked one level at a time:
// peek and the error cases walk no levels, sift up reads the parent at
// each level climbed, and sift down after an extract reads both children
// one after the other through the single read port; delete first shifts
// the entries on the path from its slot to the root down one level. Only
// one word is in work at a time, while a finished result may wait in the
// output register. No clearing pass is needed after reset.
module binary_min_heap_edge_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// from_vertex[7:0], to_vertex[15:8], key_weight[31:16], heap_index[41:32], zeros
	input  logic [47:0] s_tdata,
	// mode[2:0]
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// out_from[8:0], out_to[17:9], out_weight[34:18], entry_count[45:35], zeros
	output logic [47:0] m_tdata,
	// status[1:0]
	output logic [1:0]  m_tuser
);
	import bmheq_pkg::*;

	entry_t   in_entry, rd_data;
	ram_req_t ram_req;
	result_t  res, out_q;
	logic     res_valid, res_ready, m_valid_q;

	assign in_entry.from_v = s_tdata[7:0];
	assign in_entry.to_v   = s_tdata[15:8];
	assign in_entry.weight = s_tdata[31:16];

	bmheq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_mode   (mode_e'(s_tuser)),
		.in_entry  (in_entry),
		.in_index  (s_tdata[41:32]),
		.ram_req   (ram_req),
		.ram_rdata (rd_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	bmheq_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.raddr (ram_req.raddr),
		.rdata (rd_data)
	);

	assign res_ready = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_ready) begin
			m_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {2'b00, out_q.entry_count, out_q.out_weight, out_q.out_to,
		out_q.out_from};

endmodule

// ----- src/bmheq_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read.
// Depends on nothing.
module bmheq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- src/bmheq_ctrl.sv -----
// Sequencer of the edge queue: decodes a word and walks the heap in the RAM.
// Depends on bmheq_pkg; drives the heap RAM through a request struct.
module bmheq_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  bmheq_pkg::mode_e           in_mode,
	input  bmheq_pkg::entry_t          in_entry,
	input  logic [bmheq_pkg::IDX_W-1:0] in_index,
	output bmheq_pkg::ram_req_t        ram_req,
	input  bmheq_pkg::entry_t          ram_rdata,
	output logic                       res_valid,
	input  logic                       res_ready,
	output bmheq_pkg::result_t         res
);
	import bmheq_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE   = 11'b000_0000_0001,
		S_UP     = 11'b000_0000_0010,
		S_UP_CMP = 11'b000_0000_0100,
		S_CAP    = 11'b000_0000_1000,
		S_DL     = 11'b000_0001_0000,
		S_DL_CMP = 11'b000_0010_0000,
		S_LAST   = 11'b000_0100_0000,
		S_DN     = 11'b000_1000_0000,
		S_DN_L   = 11'b001_0000_0000,
		S_DN_R   = 11'b010_0000_0000,
		S_FIN    = 11'b100_0000_0000
	} state_t;

	state_t             state_q, state_n;
	mode_e              op_q, op_n;
	entry_t             x_q, x_n;
	entry_t             bestd_q, bestd_n;
	logic               bsel_q, bsel_n;
	logic               rok_q, rok_n;
	logic [IDX_W-1:0]   i_q, i_n;
	logic [CNT_W-1:0]   cnt_q, cnt_n;
	result_t            res_q, res_n;

	logic [IDX_W-1:0]   parent;
	logic [CNT_W-1:0]   left_c, right_c, cnt_dec;
	logic [WEIGHT_BITS-1:0] best_w;
	logic               take_r;

	assign parent  = (i_q - IDX_W'(1)) >> 1;
	assign left_c  = {i_q, 1'b1};
	assign right_c = left_c + CNT_W'(1);
	assign cnt_dec = cnt_q - CNT_W'(1);
	assign best_w  = bsel_q ? bestd_q.weight : x_q.weight;
	assign take_r  = rok_q && (ram_rdata.weight < best_w);

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_FIN);

	always_comb begin
		res             = res_q;
		res.entry_count = cnt_q;
	end

	always_comb begin
		state_n = state_q;
		op_n    = op_q;
		x_n     = x_q;
		bestd_n = bestd_q;
		bsel_n  = bsel_q;
		rok_n   = rok_q;
		i_n     = i_q;
		cnt_n   = cnt_q;
		res_n   = res_q;
		ram_req = '0;
		unique case (state_q)
			S_IDLE: begin
				ram_req.raddr = (in_mode == MODE_DELETE) ? in_index : '0;
				if (in_valid) begin
					op_n             = in_mode;
					res_n.status     = STATUS_OK;
					res_n.out_from   = '1;
					res_n.out_to     = '1;
					res_n.out_weight = '1;
					state_n          = S_FIN;
					case (in_mode)
						MODE_INSERT: begin
							if (cnt_q >= CNT_W'(CAPACITY)) begin
								res_n.status = STATUS_FULL;
							end else begin
								x_n     = in_entry;
								i_n     = cnt_q[IDX_W-1:0];
								cnt_n   = cnt_q + CNT_W'(1);
								state_n = S_UP;
							end
						end
						MODE_EXTRACT, MODE_PEEK: begin
							if (cnt_q == '0) begin
								res_n.status = STATUS_EMPTY;
							end else begin
								state_n = S_CAP;
							end
						end
						MODE_DECREASE: begin
							if ({1'b0, in_index} >= cnt_q) begin
								res_n.status = STATUS_INDEX;
							end else begin
								x_n     = in_entry;
								i_n     = in_index;
								state_n = S_UP;
							end
						end
						MODE_DELETE: begin
							if ({1'b0, in_index} >= cnt_q) begin
								res_n.status = STATUS_INDEX;
							end else begin
								i_n     = in_index;
								state_n = S_CAP;
							end
						end
						default: ;
					endcase
				end
			end
			S_UP: begin
				if (i_q == '0) begin
					ram_req.we    = 1'b1;
					ram_req.waddr = i_q;
					ram_req.wdata = x_q;
					state_n       = S_FIN;
				end else begin
					ram_req.raddr = parent;
					state_n       = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = i_q;
				if (ram_rdata.weight > x_q.weight) begin
					ram_req.wdata = ram_rdata;
					i_n           = parent;
					state_n       = S_UP;
				end else begin
					ram_req.wdata = x_q;
					state_n       = S_FIN;
				end
			end
			S_CAP: begin
				res_n.out_from   = {1'b0, ram_rdata.from_v};
				res_n.out_to     = {1'b0, ram_rdata.to_v};
				res_n.out_weight = {1'b0, ram_rdata.weight};
				if (op_q == MODE_PEEK) begin
					state_n = S_FIN;
				end else if (op_q == MODE_DELETE) begin
					state_n = S_DL;
				end else begin
					cnt_n         = cnt_dec;
					ram_req.raddr = cnt_dec[IDX_W-1:0];
					state_n       = (cnt_dec == '0) ? S_FIN : S_LAST;
				end
			end
			S_DL: begin
				if (i_q == '0) begin
					cnt_n         = cnt_dec;
					ram_req.raddr = cnt_dec[IDX_W-1:0];
					state_n       = (cnt_dec == '0) ? S_FIN : S_LAST;
				end else begin
					ram_req.raddr = parent;
					state_n       = S_DL_CMP;
				end
			end
			S_DL_CMP: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = i_q;
				ram_req.wdata = ram_rdata;
				i_n           = parent;
				state_n       = S_DL;
			end
			S_LAST: begin
				x_n     = ram_rdata;
				i_n     = '0;
				state_n = S_DN;
			end
			S_DN: begin
				if (left_c >= cnt_q) begin
					ram_req.we    = 1'b1;
					ram_req.waddr = i_q;
					ram_req.wdata = x_q;
					state_n       = S_FIN;
				end else begin
					ram_req.raddr = left_c[IDX_W-1:0];
					state_n       = S_DN_L;
				end
			end
			S_DN_L: begin
				bsel_n        = ram_rdata.weight < x_q.weight;
				bestd_n       = ram_rdata;
				rok_n         = right_c < cnt_q;
				ram_req.raddr = right_c[IDX_W-1:0];
				state_n       = S_DN_R;
			end
			S_DN_R: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = i_q;
				if (take_r) begin
					ram_req.wdata = ram_rdata;
					i_n           = right_c[IDX_W-1:0];
					state_n       = S_DN;
				end else if (bsel_q) begin
					ram_req.wdata = bestd_q;
					i_n           = left_c[IDX_W-1:0];
					state_n       = S_DN;
				end else begin
					ram_req.wdata = x_q;
					state_n       = S_FIN;
				end
			end
			S_FIN: begin
				if (res_ready) begin
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_n;
			cnt_q   <= cnt_n;
		end
	end

	always_ff @(posedge clk) begin
		op_q    <= op_n;
		x_q     <= x_n;
		bestd_q <= bestd_n;
		bsel_q  <= bsel_n;
		rok_q   <= rok_n;
		i_q     <= i_n;
		res_q   <= res_n;
	end

endmodule

// ----- src/bmheq_checker.sv -----
// Port-level checker of the edge queue, bound to the top level.
// Depends on the assertion macros header.
`include "binary_min_heap_edge_queue_macros.svh"

module bmheq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic [1:0]  m_tuser
);

	`BMHEQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled output word changed")
	`BMHEQ_ASSERT_NEXT(a_one_word, s_tvalid && s_tready, !s_tready, "second word taken while one is in work")
	`BMHEQ_ASSERT_NOW(a_count_max, m_tvalid, m_tdata[45:35] <= 11'd1024, "entry count beyond capacity")
	`BMHEQ_ASSERT_NOW(a_empty_none, m_tvalid && m_tuser == 2'd2, m_tdata[34:0] == 35'h7_FFFF_FFFF && m_tdata[45:35] == 11'd0, "empty result not blank")

endmodule

bind binary_min_heap_edge_queue bmheq_checker u_bmheq_checker (.*);

// ----- sim/tb.sv -----
// Self-checking testbench of the binary min-heap edge queue.
// Depends on bmheq_pkg and binary_min_heap_edge_queue; a heap model predicts each result word.
`timescale 1ns / 100ps

module tb;
	import bmheq_pkg::*;

	typedef struct packed {
		logic [1:0]  status;
		logic [8:0]  from_v;
		logic [8:0]  to_v;
		logic [16:0] weight;
		logic [10:0] count;
	} heap_result_t;

	class heap_scoreboard;
		entry_t       slots[CAPACITY];
		int           held;
		heap_result_t pending[$];
		int           errors;

		function void swap_slots(int a, int b);
			entry_t t;
			t = slots[a];
			slots[a] = slots[b];
			slots[b] = t;
		endfunction

		function void sift_up(int i);
			int p;
			while (i != 0) begin
				p = (i - 1) / 2;
				if (slots[p].weight > slots[i].weight) begin
					swap_slots(i, p);
					i = p;
				end else begin
					break;
				end
			end
		endfunction

		function void pop_root();
			int i;
			int l;
			int r;
			int best;
			held--;
			if (held > 0) begin
				slots[0] = slots[held];
				i = 0;
				forever begin
					l = 2 * i + 1;
					r = 2 * i + 2;
					best = i;
					if (l < held && slots[l].weight < slots[best].weight) best = l;
					if (r < held && slots[r].weight < slots[best].weight) best = r;
					if (best == i) break;
					swap_slots(i, best);
					i = best;
				end
			end
		endfunction

		function void note_word(logic [2:0] mode, logic [47:0] data);
			heap_result_t res;
			entry_t e;
			int idx;
			int i;
			e.from_v = data[7:0];
			e.to_v = data[15:8];
			e.weight = data[31:16];
			idx = data[41:32];
			res.status = STATUS_OK;
			res.from_v = '1;
			res.to_v = '1;
			res.weight = '1;
			case (mode)
				MODE_INSERT: begin
					if (held >= CAPACITY) begin
						res.status = STATUS_FULL;
					end else begin
						slots[held] = e;
						held++;
						sift_up(held - 1);
					end
				end
				MODE_EXTRACT, MODE_PEEK: begin
					if (held == 0) begin
						res.status = STATUS_EMPTY;
					end else begin
						res.from_v = {1'b0, slots[0].from_v};
						res.to_v = {1'b0, slots[0].to_v};
						res.weight = {1'b0, slots[0].weight};
						if (mode == MODE_EXTRACT) pop_root();
					end
				end
				MODE_DECREASE: begin
					if (idx >= held) begin
						res.status = STATUS_INDEX;
					end else begin
						slots[idx] = e;
						sift_up(idx);
					end
				end
				MODE_DELETE: begin
					if (idx >= held) begin
						res.status = STATUS_INDEX;
					end else begin
						res.from_v = {1'b0, slots[idx].from_v};
						res.to_v = {1'b0, slots[idx].to_v};
						res.weight = {1'b0, slots[idx].weight};
						i = idx;
						while (i != 0) begin
							swap_slots(i, (i - 1) / 2);
							i = (i - 1) / 2;
						end
						pop_root();
					end
				end
				default: ;
			endcase
			res.count = 11'(held);
			pending.push_back(res);
		endfunction

		function void check_word(logic [1:0] st, logic [47:0] data);
			heap_result_t exp_r;
			heap_result_t got;
			got.status = st;
			got.from_v = data[8:0];
			got.to_v = data[17:9];
			got.weight = data[34:18];
			got.count = data[45:35];
			if (pending.size() == 0) begin
				$display("%0t: unexpected result word %h", $time, got);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			if (got.status !== exp_r.status)
				$display("%0t: status expected %0d actual %0d", $time, exp_r.status, got.status);
			if (got.from_v !== exp_r.from_v)
				$display("%0t: out_from expected %h actual %h", $time, exp_r.from_v, got.from_v);
			if (got.to_v !== exp_r.to_v)
				$display("%0t: out_to expected %h actual %h", $time, exp_r.to_v, got.to_v);
			if (got.weight !== exp_r.weight)
				$display("%0t: out_weight expected %h actual %h", $time, exp_r.weight, got.weight);
			if (got.count !== exp_r.count)
				$display("%0t: entry_count expected %0d actual %0d", $time, exp_r.count, got.count);
			if (got !== exp_r) errors++;
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic [1:0]  m_tuser;

	heap_scoreboard board;
	bit  calm;
	int  idle_cycles;

	binary_min_heap_edge_queue i_dut (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		if (s_tvalid && s_tready) board.note_word(s_tuser, s_tdata);
		if (m_tvalid && m_tready) board.check_word(m_tuser, m_tdata);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		int hold;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			hold = $urandom_range(1, 100);
			if (!calm && hold < 30) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 30)) @(posedge clk);
		end
	end

	task automatic send_word(logic [2:0] mode, logic [7:0] fv, logic [7:0] tv,
	                         logic [15:0] w, logic [9:0] idx);
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {6'b0, idx, w, tv, fv};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_random(int want_ins);
		int pick;
		logic [15:0] w;
		logic [9:0] idx;
		pick = $urandom_range(0, 99);
		w = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 7)) : 16'($urandom);
		idx = (board.held > 0 && $urandom_range(0, 7) != 0) ?
			10'($urandom_range(0, board.held - 1)) : 10'($urandom);
		if (pick < want_ins) send_word(MODE_INSERT, 8'($urandom), 8'($urandom), w, idx);
		else if (pick < want_ins + 12)
			send_word(MODE_EXTRACT, 8'($urandom), 8'($urandom), w, idx);
		else if (pick < want_ins + 18)
			send_word(MODE_PEEK, 8'($urandom), 8'($urandom), w, idx);
		else if (pick < want_ins + 26)
			send_word(MODE_DECREASE, 8'($urandom), 8'($urandom), w, idx);
		else if (pick < want_ins + 34)
			send_word(MODE_DELETE, 8'($urandom), 8'($urandom), w, idx);
		else send_word(3'($urandom_range(5, 7)), 8'($urandom), 8'($urandom), w, idx);
	endtask

	initial begin
		board = new();
		calm = 1'b0;
		idle_cycles = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(MODE_EXTRACT, 8'h00, 8'h00, 16'h0000, 10'h000);
		send_word(MODE_PEEK, 8'hff, 8'hff, 16'hffff, 10'h3ff);
		send_word(MODE_DECREASE, 8'h12, 8'h34, 16'h0001, 10'h000);
		send_word(MODE_DELETE, 8'h12, 8'h34, 16'h0001, 10'h000);
		send_word(MODE_INSERT, 8'hff, 8'h00, 16'hffff, 10'h3ff);
		send_word(MODE_INSERT, 8'h00, 8'hff, 16'h0000, 10'h000);
		send_word(MODE_INSERT, 8'h5a, 8'ha5, 16'h8000, 10'h155);
		send_word(MODE_INSERT, 8'ha5, 8'h5a, 16'h8000, 10'h2aa);
		send_word(MODE_INSERT, 8'h01, 8'h02, 16'h0000, 10'h000);
		send_word(MODE_PEEK, 8'h00, 8'h00, 16'h0000, 10'h000);
		send_word(MODE_DECREASE, 8'h11, 8'h22, 16'hffff, 10'h001);
		send_word(MODE_DECREASE, 8'h33, 8'h44, 16'h0000, 10'h004);
		send_word(MODE_DECREASE, 8'h33, 8'h44, 16'h0000, 10'h005);
		send_word(MODE_DELETE, 8'h00, 8'h00, 16'h0000, 10'h003);
		send_word(MODE_DELETE, 8'h00, 8'h00, 16'h0000, 10'h3ff);
		send_word(3'd5, 8'hff, 8'hff, 16'hffff, 10'h3ff);
		send_word(3'd6, 8'h00, 8'h00, 16'h0000, 10'h000);
		send_word(3'd7, 8'h00, 8'h00, 16'h0000, 10'h000);
		send_word(MODE_EXTRACT, 8'h00, 8'h00, 16'h0000, 10'h000);
		send_word(MODE_DELETE, 8'h00, 8'h00, 16'h0000, 10'h000);

		// Fill the heap to capacity, then try one more insert and drain part of it.
		while (board.held < CAPACITY) send_random(100);
		send_word(MODE_INSERT, 8'h77, 8'h88, 16'h1234, 10'h000);
		repeat (20) send_random(0);
		calm = 1'b1;
		repeat (20) send_random(40);
		s_tvalid <= 1'b0;

		while (board.pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (board.errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+src
src/bmheq_pkg.sv
src/bmheq_ram.sv
src/bmheq_ctrl.sv
src/binary_min_heap_edge_queue.sv
src/bmheq_checker.sv
sim/tb.sv
